// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// File: rtl/mqufi_pkg.sv
// ----------------------------------------------------------------------------
// mqufi_pkg
// Sizes, operation and result codes, and transaction types of the class
// queue bank.
// ----------------------------------------------------------------------------
package mqufi_pkg;

   // Bank geometry
   localparam int NUM_QUEUES  = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_BITS    = 16;

   // Derived widths
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int Q_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int S_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int C_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int P_W       = C_W + 1;
   localparam int ENTRY_W   = TAG_BITS + 1;

   // Operation codes
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Result codes
   typedef enum logic [1:0] {
      RC_OK     = 2'd0,
      RC_FULL   = 2'd1,
      RC_EMPTY  = 2'd2,
      RC_BADIDX = 2'd3
   } result_code_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  queue_index;
      logic [15:0] entry_tag;
      logic        urgent;
   } req_type;

   typedef struct packed {
      result_code_type result_code;
      logic [15:0]     popped_tag;
      logic            popped_urgent;
      logic [3:0]      occupancy;
   } rsp_type;

endpackage

// File: rtl/multi_queue_urgent_front_insert.sv
// ----------------------------------------------------------------------------
// multi_queue_urgent_front_insert
// Bank of bounded class queues with push-back, urgent push-front and pop.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one operation per transaction: a push
//   of a tag into a class queue (urgent pushes go to the head) or a pop of a
//   queue's head. rsp_valid/rsp_ready/rsp_data return exactly one result per
//   operation, in order: a status code, the popped tag and urgency, and the
//   queue occupancy after the operation.
//   Each queue is a circular buffer in a shared entry memory, with a head
//   pointer and a count per queue. One pointer adder with wrap correction
//   computes every slot address and the advanced head.
//   From acceptance, a push, a refused operation or a bad index passes through
//   EXEC and FINISH before rsp_valid; a successful pop also passes through
//   READ, the registered memory read. One operation is in flight at a time,
//   so a new request is taken only after the previous one leaves FINISH.
//   A finished result waits in the output register; while it is stalled the
//   block still accepts and processes the next request, and holds that result
//   until the output register frees.
//   Reset clears all counts and head pointers; the entry memory is not
//   cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_queue_urgent_front_insert
   import mqufi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [C_W-1:0] count_ff [NUM_QUEUES];
   logic [S_W-1:0] head_ff  [NUM_QUEUES];
   logic [C_W-1:0] count_in;
   logic [S_W-1:0] head_in;
   logic           count_we;
   logic           head_we;

   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;

   logic [Q_W-1:0] q_idx;
   logic           idx_ok;
   logic [C_W-1:0] cur_cnt;
   logic [S_W-1:0] cur_head;
   logic           is_full;
   logic           is_empty;
   logic [C_W-1:0] ptr_off;
   logic [P_W-1:0] ptr_sum;
   logic [P_W-1:0] ptr_wrap;
   logic [S_W-1:0] slot;
   logic           out_free;

   // Look up the addressed queue
   assign q_idx    = req_ff.queue_index[Q_W-1:0];
   assign idx_ok   = {1'b0, req_ff.queue_index} < 6'(NUM_QUEUES);
   assign cur_cnt  = count_ff[q_idx];
   assign cur_head = head_ff[q_idx];
   assign is_full  = cur_cnt == C_W'(QUEUE_DEPTH);
   assign is_empty = cur_cnt == '0;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Select the pointer offset: tail, one before head, head, or next head
   always_comb begin
      ptr_off = '0;
      case (state_ff)
         ST_EXEC: begin
            if (req_ff.kind == KIND_PUSH) begin
               ptr_off = req_ff.urgent ? C_W'(QUEUE_DEPTH - 1) : cur_cnt;
            end
         end
         ST_READ: ptr_off = C_W'(1);
         default: ptr_off = '0;
      endcase
   end

   // Shared pointer adder with modulo-depth wrap
   assign ptr_sum  = P_W'(cur_head) + P_W'(ptr_off);
   assign ptr_wrap = (ptr_sum >= P_W'(QUEUE_DEPTH)) ? ptr_sum - P_W'(QUEUE_DEPTH) : ptr_sum;
   assign slot     = S_W'(ptr_wrap);

   // Form the memory access
   assign mem_addr = ADDR_W'(q_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   assign wr_data  = {req_ff.urgent, TAG_BITS'(req_ff.entry_tag)};
   assign mem_we   = (state_ff == ST_EXEC) && idx_ok && (req_ff.kind == KIND_PUSH) && !is_full;

   // Sequence one operation
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      count_we     = 1'b0;
      count_in     = cur_cnt;
      head_we      = 1'b0;
      head_in      = cur_head;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '{result_code: RC_OK, popped_tag: '0, popped_urgent: 1'b0,
                         occupancy: '0};
            state_in = ST_FINISH;
            if (!idx_ok) begin
               res_in.result_code = RC_BADIDX;
            end else if (req_ff.kind == KIND_PUSH) begin
               if (is_full) begin
                  res_in.result_code = RC_FULL;
                  res_in.occupancy   = 4'(cur_cnt);
               end else begin
                  count_we         = 1'b1;
                  count_in         = cur_cnt + C_W'(1);
                  res_in.occupancy = 4'(count_in);
                  if (req_ff.urgent) begin
                     head_we = 1'b1;
                     head_in = slot;
                  end
               end
            end else begin
               if (is_empty) begin
                  res_in.result_code = RC_EMPTY;
               end else begin
                  count_we         = 1'b1;
                  count_in         = cur_cnt - C_W'(1);
                  res_in.occupancy = 4'(count_in);
                  state_in         = ST_READ;
               end
            end
         end
         ST_READ: begin
            head_we              = 1'b1;
            head_in              = slot;
            res_in.popped_tag    = 16'(rd_data_ff[TAG_BITS-1:0]);
            res_in.popped_urgent = rd_data_ff[TAG_BITS];
            state_in             = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, queue pointers and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (count_we) begin
            count_ff[q_idx] <= count_in;
         end
         if (head_we) begin
            head_ff[q_idx] <= head_in;
         end
      end
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      res_ff <= res_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Entry memory: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wr_data;
      end
      rd_data_ff <= mem[mem_addr];
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `ASSERT_NEVER(a_count_bound, clock, reset, (state_ff != ST_IDLE) && (cur_cnt > C_W'(QUEUE_DEPTH)), "queue count above depth")
   `ASSERT_NEVER(a_badidx_no_write, clock, reset, mem_we && !idx_ok, "write with bad queue index")
   `ASSERT_CLK(a_pop_reads, clock, reset, (state_ff == ST_EXEC && idx_ok && req_ff.kind == KIND_POP && !is_empty) |=> (state_ff == ST_READ), "pop did not read entry")
   `ASSERT_CLK(a_occ_bound, clock, reset, rsp_valid_ff |-> (rsp_data_ff.occupancy <= 4'(QUEUE_DEPTH)), "occupancy above depth")

endmodule

// File: tb/multi_queue_urgent_front_insert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_urgent_front_insert_test
// Self-checking bench for the class queue bank with urgent push-front.
// A queue of pending operations feeds a clocked driver. Every accepted
// transaction runs through a behavioral copy of the queue bank, and the
// predicted result is queued. A clocked monitor compares each returned result,
// field by field, with the oldest prediction. Both sides idle at random. The
// receiver holds off once for a long stretch, and the sender pauses once until
// the bank has drained.
// ----------------------------------------------------------------------------
module multi_queue_urgent_front_insert_test;
   import mqufi_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 20;
   localparam int HOLD_START   = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_FIRST  = 1300;
   localparam int QUIET_LAST   = 1550;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [15:0] TAG_KEEP =
      (TAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TAG_BITS) - 1);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Behavioral copy of the bank: slot 0 is the head of each queue
   logic [15:0] model_tag [NUM_QUEUES][QUEUE_DEPTH];
   logic        model_urg [NUM_QUEUES][QUEUE_DEPTH];
   int          model_count [NUM_QUEUES];

   req_type pending_ops [$];
   rsp_type awaited_results [$];

   int  accepted_count = 0;
   int  checked_count = 0;
   int  mismatch_count = 0;
   int  code_tally [4];
   int  cycle_count = 0;
   int  hold_left = 0;
   logic hold_done = 1'b0;
   logic quiet_window;

   multi_queue_urgent_front_insert u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign quiet_window = (accepted_count >= QUIET_FIRST) && (accepted_count < QUIET_LAST);

   // Apply one operation to the bank copy and return the result it must produce
   function automatic rsp_type apply_queue_op(req_type op);
      rsp_type     r;
      int          q;
      int          n;
      int          i;
      logic [15:0] tag;
      r = '0;
      r.result_code = RC_OK;
      q = op.queue_index;
      tag = op.entry_tag & TAG_KEEP;
      if (q >= NUM_QUEUES) begin
         r.result_code = RC_BADIDX;
      end else begin
         n = model_count[q];
         if (op.kind == KIND_PUSH) begin
            if (n >= QUEUE_DEPTH) begin
               r.result_code = RC_FULL;
            end else if (op.urgent) begin
               // urgent entries jump ahead of everything, earlier urgent ones too
               for (i = n; i > 0; i--) begin
                  model_tag[q][i] = model_tag[q][i-1];
                  model_urg[q][i] = model_urg[q][i-1];
               end
               model_tag[q][0] = tag;
               model_urg[q][0] = 1'b1;
               n++;
            end else begin
               model_tag[q][n] = tag;
               model_urg[q][n] = 1'b0;
               n++;
            end
         end else begin
            if (n == 0) begin
               r.result_code = RC_EMPTY;
            end else begin
               r.popped_tag = model_tag[q][0];
               r.popped_urgent = model_urg[q][0];
               for (i = 0; i < n - 1; i++) begin
                  model_tag[q][i] = model_tag[q][i+1];
                  model_urg[q][i] = model_urg[q][i+1];
               end
               n--;
            end
         end
         model_count[q] = n;
         r.occupancy = 4'(n);
      end
      code_tally[r.result_code]++;
      return r;
   endfunction

   function automatic req_type make_op(logic kind, logic [4:0] q, logic [15:0] tag,
                                       logic urgent);
      req_type op;
      op.kind = kind;
      op.queue_index = q;
      op.entry_tag = tag;
      op.urgent = urgent;
      return op;
   endfunction

   // Queue random operations, mostly aimed at a few hot queues so they fill and empty
   task automatic queue_random_ops(int count);
      int   i;
      int   pick;
      int   push_bias;
      int   hot_base;
      int   q;
      logic kind;
      push_bias = 50;
      hot_base = 0;
      for (i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            case ((i / 100) % 5)
               0: push_bias = 80;
               1: push_bias = 50;
               2: push_bias = 20;
               3: push_bias = 65;
               default: push_bias = 35;
            endcase
            hot_base = $urandom_range(NUM_QUEUES - 4);
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            q = $urandom_range(31, NUM_QUEUES);
         end else if (pick < 14) begin
            q = $urandom_range(NUM_QUEUES - 1);
         end else begin
            q = hot_base + $urandom_range(3);
         end
         kind = ($urandom_range(99) < push_bias) ? KIND_PUSH : KIND_POP;
         pending_ops.push_back(make_op(kind, 5'(q), 16'($urandom), 1'($urandom_range(1))));
      end
   endtask

   // Wait until every queued operation is sent and every result is back
   task automatic wait_for_drain();
      while (pending_ops.size() != 0 || req_valid || awaited_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: present the next operation, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(apply_queue_op(req_data));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 &&
                (quiet_window || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_data <= pending_ops.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_START) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_window || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: code %0d tag %h urg %b occ %0d",
                        rsp_data.result_code, rsp_data.popped_tag,
                        rsp_data.popped_urgent, rsp_data.occupancy);
            end
         end else begin
            want = awaited_results.pop_front();
            checked_count++;
            if (rsp_data.result_code !== want.result_code ||
                rsp_data.popped_tag !== want.popped_tag ||
                rsp_data.popped_urgent !== want.popped_urgent ||
                rsp_data.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch on result %0d: expected code %0d tag %h urg %b occ %0d,",
                           checked_count, want.result_code, want.popped_tag,
                           want.popped_urgent, want.occupancy);
                  $display("   got code %0d tag %h urg %b occ %0d",
                           rsp_data.result_code, rsp_data.popped_tag,
                           rsp_data.popped_urgent, rsp_data.occupancy);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int k;
      for (k = 0; k < NUM_QUEUES; k++) begin
         model_count[k] = 0;
      end
      for (k = 0; k < 4; k++) begin
         code_tally[k] = 0;
      end

      // Hold reset, then release
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, tag extremes, urgent ordering, full, drain, bad index
      pending_ops.push_back(make_op(KIND_POP, 5'd0, 16'h0000, 1'b0));
      pending_ops.push_back(make_op(KIND_PUSH, 5'd15, 16'hFFFF, 1'b0));
      pending_ops.push_back(make_op(KIND_PUSH, 5'd15, 16'h0000, 1'b1));
      pending_ops.push_back(make_op(KIND_PUSH, 5'd15, 16'hA5A5, 1'b1));
      for (k = 0; k < 5; k++) begin
         pending_ops.push_back(make_op(KIND_PUSH, 5'd15, 16'h1000 + 16'(k), 1'(k)));
      end
      pending_ops.push_back(make_op(KIND_PUSH, 5'd15, 16'h7777, 1'b1));
      for (k = 0; k < QUEUE_DEPTH + 1; k++) begin
         pending_ops.push_back(make_op(KIND_POP, 5'd15, 16'h5A5A, 1'b1));
      end
      pending_ops.push_back(make_op(KIND_PUSH, 5'(NUM_QUEUES), 16'hFFFF, 1'b1));
      pending_ops.push_back(make_op(KIND_POP, 5'd31, 16'hFFFF, 1'b1));
      pending_ops.push_back(make_op(KIND_PUSH, 5'd0, 16'h0000, 1'b0));
      pending_ops.push_back(make_op(KIND_POP, 5'd0, 16'h0000, 1'b0));

      // Random traffic, with one full drain partway through
      queue_random_ops(1100);
      wait_for_drain();
      queue_random_ops(700);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d queue operations: %0d ok, %0d full, %0d empty, %0d bad index",
               accepted_count, code_tally[RC_OK], code_tally[RC_FULL],
               code_tally[RC_EMPTY], code_tally[RC_BADIDX]);
      $display("Checked %0d results with %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
